// ===== sv/btc_pkg.sv =====
// Shared types, codes and helpers for the backlash take-up controller.
package btc_pkg;

	localparam int STEPS_W    = 16;
	localparam int RATE_W     = 20;
	localparam int INC_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int AXES       = 2;

	localparam int TICK_RATE_HZ_DEF = 50000;
	localparam int QUEUE_DEPTH_DEF  = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TAKEUP_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAKEUP_Z = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_X    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FM_MODE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_DIRS = 3'd7;

	// First move modes; the unused code behaves as reference
	localparam logic [1:0] FM_REF    = 2'd0;
	localparam logic [1:0] FM_SKIP   = 2'd1;
	localparam logic [1:0] FM_ALWAYS = 2'd2;

	typedef enum logic [2:0] {
		OP_ARM    = 3'd0,
		OP_STEP   = 3'd1,
		OP_SYNC   = 3'd2,
		OP_UNSYNC = 3'd3,
		OP_QUEUE  = 3'd4,
		OP_ABORT  = 3'd5,
		OP_INIT   = 3'd6,
		OP_NOP    = 3'd7
	} btc_op_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic               axis;
		logic               direction;
		logic               arm_enable;
		logic [RATE_W-1:0]  feed_rate;
		logic [STEPS_W-1:0] queued_steps;
	} btc_cmd_t;

	typedef struct packed {
		logic               step_consumed;
		logic [STEPS_W-1:0] pending_steps;
		logic [INC_W-1:0]   step_increment;
		logic               takeup_started;
	} btc_res_t;

	// Decided command on its way to the increment unit
	typedef struct packed {
		logic               step_consumed;
		logic [STEPS_W-1:0] pending_steps;
		logic               takeup_started;
		logic               inc_one;
		logic [RATE_W-1:0]  speed;
	} btc_job_t;

	function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] f,
		input logic [RATE_W-1:0] mn, input logic [RATE_W-1:0] mx);
		logic [RATE_W-1:0] s;
		s = f;
		if (s < mn) s = mn;
		if (s > mx) s = mx;
		return s;
	endfunction

endpackage

// ===== sv/btc_chan_if.sv =====
// Valid/ready channel carrying one payload beat of type T.
interface btc_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/btc_front.sv =====
// Front end: configuration registers, per-axis take-up state and command decisions.
module btc_front import btc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	btc_chan_if.sink              cmd,
	btc_chan_if.source            job
);

	logic [STEPS_W-1:0] takeup_q [AXES];
	logic [RATE_W-1:0]  min_q [AXES];
	logic [RATE_W-1:0]  max_q [AXES];
	logic [1:0]         fm_q;
	logic [1:0]         ref_q;

	logic [STEPS_W-1:0] rem_q [AXES];
	logic               synced_q [AXES];
	logic               last_dir_q [AXES];
	logic               arm_dir_q [AXES];
	logic               inc_one_q [AXES];
	logic [RATE_W-1:0]  speed_q [AXES];

	logic [STEPS_W-1:0] rem_d [AXES];
	logic               synced_d [AXES];
	logic               last_dir_d [AXES];
	logic               arm_dir_d [AXES];
	logic               inc_one_d [AXES];
	logic [RATE_W-1:0]  speed_d [AXES];

	logic    accept;
	logic    ax;
	logic    dir;
	btc_op_t op;
	logic    consumed;
	logic    started;

	assign accept = cmd.valid & job.ready;
	assign ax     = cmd.data.axis;
	assign dir    = cmd.data.direction;
	assign op     = btc_op_t'(cmd.data.opcode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			takeup_q[0] <= '0;
			takeup_q[1] <= '0;
			min_q[0]    <= RATE_W'(1);
			min_q[1]    <= RATE_W'(1);
			max_q[0]    <= RATE_W'(1);
			max_q[1]    <= RATE_W'(1);
			fm_q        <= FM_REF;
			ref_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TAKEUP_X: takeup_q[0] <= cfg_data[STEPS_W-1:0];
				CFG_TAKEUP_Z: takeup_q[1] <= cfg_data[STEPS_W-1:0];
				CFG_MIN_X:    min_q[0]    <= cfg_data[RATE_W-1:0];
				CFG_MIN_Z:    min_q[1]    <= cfg_data[RATE_W-1:0];
				CFG_MAX_X:    max_q[0]    <= cfg_data[RATE_W-1:0];
				CFG_MAX_Z:    max_q[1]    <= cfg_data[RATE_W-1:0];
				CFG_FM_MODE:  fm_q        <= cfg_data[1:0];
				CFG_REF_DIRS: ref_q       <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rem_d      = rem_q;
		synced_d   = synced_q;
		last_dir_d = last_dir_q;
		arm_dir_d  = arm_dir_q;
		inc_one_d  = inc_one_q;
		speed_d    = speed_q;
		consumed   = 1'b0;
		started    = 1'b0;
		case (op)
			OP_ARM: begin
				if (cmd.data.arm_enable && takeup_q[ax] != '0 &&
				    !(rem_q[ax] != '0 && dir == arm_dir_q[ax])) begin
					// an opposite-direction arm cancels the pending take-up
					rem_d[ax] = '0;
					if (!synced_q[ax] && fm_q == FM_SKIP)
						started = 1'b0;
					else if (!synced_q[ax] && fm_q == FM_ALWAYS)
						started = 1'b1;
					else
						started = (dir != last_dir_q[ax]);
					if (started) begin
						rem_d[ax]     = takeup_q[ax];
						arm_dir_d[ax] = dir;
						speed_d[ax]   = clamp_rate(cmd.data.feed_rate, min_q[ax], max_q[ax]);
						inc_one_d[ax] = 1'b0;
					end
				end
			end
			OP_STEP: begin
				if (rem_q[ax] != '0) begin
					rem_d[ax] = rem_q[ax] - STEPS_W'(1);
					if (rem_q[ax] == STEPS_W'(1)) begin
						last_dir_d[ax] = dir;
						synced_d[ax]   = 1'b1;
					end
					consumed = 1'b1;
				end
			end
			OP_SYNC: begin
				last_dir_d[ax] = dir;
				synced_d[ax]   = 1'b1;
				rem_d[ax]      = '0;
			end
			OP_UNSYNC: begin
				synced_d[ax] = 1'b0;
				rem_d[ax]    = '0;
			end
			OP_QUEUE: begin
				if (cmd.data.queued_steps != '0 && rem_q[ax] == '0) begin
					rem_d[ax]     = cmd.data.queued_steps;
					arm_dir_d[ax] = dir;
					speed_d[ax]   = clamp_rate(min_q[ax], min_q[ax], max_q[ax]);
					inc_one_d[ax] = 1'b0;
					started       = 1'b1;
				end
			end
			OP_ABORT: begin
				rem_d[0] = '0;
				rem_d[1] = '0;
			end
			OP_INIT: begin
				for (int b = 0; b < AXES; b++) begin
					last_dir_d[b] = ref_q[b];
					arm_dir_d[b]  = ref_q[b];
					synced_d[b]   = 1'b0;
					rem_d[b]      = '0;
					speed_d[b]    = min_q[b];
					inc_one_d[b]  = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < AXES; b++) begin
				rem_q[b]      <= '0;
				synced_q[b]   <= 1'b0;
				last_dir_q[b] <= 1'b0;
				arm_dir_q[b]  <= 1'b0;
				inc_one_q[b]  <= 1'b1;
			end
		end else if (accept) begin
			rem_q      <= rem_d;
			synced_q   <= synced_d;
			last_dir_q <= last_dir_d;
			arm_dir_q  <= arm_dir_d;
			inc_one_q  <= inc_one_d;
		end
	end

	// speed is only read once inc_one has dropped
	always_ff @(posedge clk) begin
		if (accept) speed_q <= speed_d;
	end

	assign cmd.ready = job.ready;
	assign job.valid = cmd.valid;
	always_comb begin
		job.data.step_consumed  = consumed;
		job.data.pending_steps  = rem_d[ax];
		job.data.takeup_started = started;
		job.data.inc_one        = inc_one_d[ax];
		job.data.speed          = speed_d[ax];
	end

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !(consumed && started))
		else $error("consume and take-up start on the same beat");

	a_step_dec: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_STEP && rem_q[ax] != '0 |=>
		rem_q[$past(ax)] == $past(rem_q[ax]) - STEPS_W'(1))
		else $error("consumed step did not count down");

	a_start_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept && started |=> rem_q[$past(ax)] != '0)
		else $error("take-up started with zero length");

endmodule

// ===== sv/btc_queue.sv =====
// Short queue between the decision front end and the increment unit.
module btc_queue import btc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	btc_chan_if.sink   wr,
	btc_chan_if.source rd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	btc_job_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            push;
	logic            pop;

	assign wr.ready = (cnt_q != CW'(DEPTH));
	assign rd.valid = (cnt_q != '0);
	assign rd.data  = mem_q[rd_ptr_q];
	assign push     = wr.valid & wr.ready;
	assign pop      = rd.valid & rd.ready;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr.data;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count past depth");

	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("queue count lost a push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("empty queue with pointers apart");

endmodule

// ===== sv/btc_incr.sv =====
// Back end: speed * 2^31 / tick rate by reciprocal multiplication, giving the phase increment.
module btc_incr import btc_pkg::*; #(
	parameter int TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	btc_chan_if.sink   job,
	btc_chan_if.source res
);

	// speed * 2^31 / tick equals (speed * RECIP) >> FRAC_SH exactly while speed and tick
	// stay below 2^20; RECIP is split in halves so each product fits in PROD_W (51) bits
	localparam int FRAC_SH = 40;
	localparam int HALF_W  = 31;
	localparam int RECIP_W = 2 * HALF_W;
	localparam int PROD_W  = RATE_W + HALF_W;
	localparam int DROP    = FRAC_SH - HALF_W;
	localparam int QUO_W   = PROD_W + 1 - DROP;

	localparam logic [71:0] RECIP_WIDE =
		((72'd1 << (FRAC_SH + 31)) / 72'(TICK_RATE_HZ)) + 72'd1;
	localparam logic [HALF_W-1:0] RECIP_HI = RECIP_WIDE[RECIP_W-1:HALF_W];
	localparam logic [HALF_W-1:0] RECIP_LO = RECIP_WIDE[HALF_W-1:0];

	typedef struct packed {
		logic               step_consumed;
		logic [STEPS_W-1:0] pending_steps;
		logic               takeup_started;
		logic               inc_one;
		logic [PROD_W-1:0]  prod_hi;
		logic [RATE_W-1:0]  lo_carry;
	} mul_stage_t;

	mul_stage_t        mul_s1;
	mul_stage_t        mul_d;
	logic              vld_s1;
	btc_res_t          out_q;
	logic              out_vld_q;
	logic              adv;
	logic [RATE_W-1:0] spd;
	logic [QUO_W-1:0]  quo;
	logic [INC_W-1:0]  inc;

	assign adv       = !(out_vld_q && !res.ready);
	assign job.ready = adv;

	// zero speed runs as 1 step/s
	always_comb begin
		spd                  = (job.data.speed == '0) ? RATE_W'(1) : job.data.speed;
		mul_d.step_consumed  = job.data.step_consumed;
		mul_d.pending_steps  = job.data.pending_steps;
		mul_d.takeup_started = job.data.takeup_started;
		mul_d.inc_one        = job.data.inc_one;
		mul_d.prod_hi        = PROD_W'(spd) * PROD_W'(RECIP_HI);
		// low bits of the low product never reach the quotient
		mul_d.lo_carry       = RATE_W'((PROD_W'(spd) * PROD_W'(RECIP_LO)) >> HALF_W);
	end

	always_comb begin
		quo = QUO_W'(({1'b0, mul_s1.prod_hi} + (PROD_W+1)'(mul_s1.lo_carry)) >> DROP);
		if (mul_s1.inc_one)
			inc = INC_W'(1);
		else if (quo[QUO_W-1:INC_W] != '0)
			inc = '1;
		else if (quo[INC_W-1:0] == '0)
			inc = INC_W'(1);
		else
			inc = quo[INC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= job.valid;
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s1               <= mul_d;
			out_q.step_consumed  <= mul_s1.step_consumed;
			out_q.pending_steps  <= mul_s1.pending_steps;
			out_q.takeup_started <= mul_s1.takeup_started;
			out_q.step_increment <= inc;
		end
	end

	assign res.valid = out_vld_q;
	assign res.data  = out_q;

	a_inc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> out_q.step_increment != '0)
		else $error("zero phase increment delivered");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !res.ready |=> out_vld_q && $stable(out_q))
		else $error("held result beat changed");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		job.valid && adv |=> vld_s1)
		else $error("popped beat did not enter the multiplier");

endmodule

// ===== sv/backlash_takeup_controller.sv =====
// Path: an accepted command is written into the queue, then registered in the reciprocal
// multiply stage and the output register; older waiting beats or a held res delay it further.
// Throughput: one command per cycle; the queue and the two-stage multiplier sustain it,
// and a held result stalls the multiplier while the queue takes up to QUEUE_DEPTH more.
// Reset (arst_n low): all axes unsynced, no take-up pending, directions 0, increment 1,
// configuration at defaults; the block is ready right after reset, no clearing pass.
module backlash_takeup_controller import btc_pkg::*; #(
	parameter int TICK_RATE_HZ = TICK_RATE_HZ_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	btc_chan_if.sink              cmd,
	btc_chan_if.source            res
);

	btc_chan_if #(.T(btc_job_t)) fq_ch ();
	btc_chan_if #(.T(btc_job_t)) qb_ch ();

	btc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.job       (fq_ch.source)
	);

	btc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fq_ch.sink),
		.rd     (qb_ch.source)
	);

	btc_incr #(.TICK_RATE_HZ(TICK_RATE_HZ)) u_incr (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (qb_ch.sink),
		.res    (res)
	);

endmodule

// ===== bench/tb_backlash_takeup_controller.sv =====
// Self-checking bench for the backlash take-up controller: random handshake pacing, checked per beat.
module tb_backlash_takeup_controller;
	import btc_pkg::*;

	localparam int TICK_HZ      = TICK_RATE_HZ_DEF;
	localparam int DRAIN_CYCLES = 45;
	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLDOFF_LEN  = 300;
	localparam int PHASE_ITEMS  = 93;
	localparam logic [1:0] FM_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	btc_chan_if #(.T(btc_cmd_t)) cmd_ch ();
	btc_chan_if #(.T(btc_res_t)) res_ch ();

	backlash_takeup_controller #(
		.TICK_RATE_HZ(TICK_HZ),
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	always #10 clk = ~clk;

	// configuration mirror
	logic [STEPS_W-1:0] takeup_len [2];
	logic [RATE_W-1:0]  rate_min [2];
	logic [RATE_W-1:0]  rate_max [2];
	logic [1:0]         fm_mode;
	logic [1:0]         ref_dirs;

	// axis state mirror
	logic [STEPS_W-1:0] remaining [2];
	logic               synced [2];
	logic               prev_dir [2];
	logic               takeup_dir [2];
	logic [INC_W-1:0]   phase_inc [2];

	btc_cmd_t cmd_backlog [$];
	btc_res_t takeup_expect [$];

	logic        no_idle = 1'b0;
	logic        holdoff_req = 1'b0;
	logic        holdoff_done;
	logic        gen_dir [2];
	int unsigned send_gap;
	int unsigned stall_left;
	int unsigned quiet_cycles = 0;
	int unsigned mismatch_count = 0;

	function automatic logic [INC_W-1:0] rate_to_phase_inc(input logic [RATE_W-1:0] sps);
		logic [63:0] q;
		q = {44'd0, (sps == '0) ? 20'd1 : sps} << 31;
		q = q / 64'(TICK_HZ);
		if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
		if (q == 64'd0) q = 64'd1;
		return q[INC_W-1:0];
	endfunction

	function automatic void begin_takeup(input logic a, input logic dir,
		input logic [STEPS_W-1:0] len, input logic [RATE_W-1:0] feed);
		logic [RATE_W-1:0] s;
		s = feed;
		if (s < rate_min[a]) s = rate_min[a];
		if (s > rate_max[a]) s = rate_max[a];
		remaining[a] = len;
		takeup_dir[a] = dir;
		phase_inc[a] = rate_to_phase_inc(s);
	endfunction

	function automatic btc_res_t predict_takeup(input btc_cmd_t c);
		btc_res_t r;
		logic a;
		logic go;
		r = '0;
		a = c.axis;
		case (c.opcode)
		OP_ARM: begin
			go = c.arm_enable && takeup_len[a] != '0;
			if (go && remaining[a] != '0) begin
				// same direction keeps the take-up in flight, opposite cancels it
				if (c.direction == takeup_dir[a]) go = 1'b0;
				else remaining[a] = '0;
			end
			if (go) begin
				if (!synced[a] && fm_mode == FM_SKIP) go = 1'b0;
				else if (synced[a] || fm_mode != FM_ALWAYS) go = (c.direction != prev_dir[a]);
			end
			if (go) begin
				begin_takeup(a, c.direction, takeup_len[a], c.feed_rate);
				r.takeup_started = 1'b1;
			end
		end
		OP_STEP: begin
			if (remaining[a] != '0) begin
				remaining[a] = remaining[a] - STEPS_W'(1);
				if (remaining[a] == '0) begin
					prev_dir[a] = c.direction;
					synced[a] = 1'b1;
				end
				r.step_consumed = 1'b1;
			end
		end
		OP_SYNC: begin
			prev_dir[a] = c.direction;
			synced[a] = 1'b1;
			remaining[a] = '0;
		end
		OP_UNSYNC: begin
			synced[a] = 1'b0;
			remaining[a] = '0;
		end
		OP_QUEUE: begin
			if (c.queued_steps != '0 && remaining[a] == '0) begin
				begin_takeup(a, c.direction, c.queued_steps, rate_min[a]);
				r.takeup_started = 1'b1;
			end
		end
		OP_ABORT: begin
			remaining[0] = '0;
			remaining[1] = '0;
		end
		OP_INIT: begin
			for (int b = 0; b < AXES; b++) begin
				prev_dir[b] = ref_dirs[b];
				takeup_dir[b] = ref_dirs[b];
				synced[b] = 1'b0;
				remaining[b] = '0;
				phase_inc[b] = rate_to_phase_inc(rate_min[b]);
			end
		end
		default: ;
		endcase
		r.pending_steps = remaining[a];
		r.step_increment = phase_inc[a];
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned x;
		if (no_idle) return 0;
		x = $urandom_range(0, 99);
		if (x < 60) return 0;
		if (x < 88) return $urandom_range(1, 3);
		if (x < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic btc_cmd_t make_cmd(input btc_op_t op, input logic a, input logic dir,
		input logic en, input logic [RATE_W-1:0] feed, input logic [STEPS_W-1:0] qlen);
		btc_cmd_t c;
		c.opcode = op;
		c.axis = a;
		c.direction = dir;
		c.arm_enable = en;
		c.feed_rate = feed;
		c.queued_steps = qlen;
		return c;
	endfunction

	// Mostly coherent arm/step runs per axis, with a slice of fully random noise.
	function automatic btc_cmd_t next_random_cmd();
		btc_cmd_t c;
		int unsigned x;
		int unsigned f;
		c.axis = 1'($urandom_range(0, 1));
		c.direction = 1'($urandom_range(0, 1));
		c.arm_enable = ($urandom_range(0, 9) != 0);
		f = $urandom_range(0, 9);
		c.feed_rate = (f == 0) ? '0 : (f == 1) ? '1 :
			(f < 5) ? RATE_W'($urandom) : RATE_W'($urandom_range(0, 5000));
		f = $urandom_range(0, 9);
		c.queued_steps = (f == 0) ? '0 : (f == 1) ? '1 :
			(f == 2) ? STEPS_W'($urandom) : STEPS_W'($urandom_range(1, 6));
		x = $urandom_range(0, 99);
		if (x < 22) begin
			c.opcode = OP_ARM;
			if ($urandom_range(0, 1) != 0) gen_dir[c.axis] = ~gen_dir[c.axis];
			c.direction = gen_dir[c.axis];
		end else if (x < 60) begin
			c.opcode = OP_STEP;
			if ($urandom_range(0, 9) != 0) c.direction = gen_dir[c.axis];
		end else if (x < 67) c.opcode = OP_SYNC;
		else if (x < 71) c.opcode = OP_UNSYNC;
		else if (x < 80) c.opcode = OP_QUEUE;
		else if (x < 84) c.opcode = OP_ABORT;
		else if (x < 89) c.opcode = OP_INIT;
		else if (x < 91) c.opcode = OP_NOP;
		else c.opcode = 3'($urandom_range(0, 7));
		return c;
	endfunction

	// sender: present the backlog, predict each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.data <= '0;
			send_gap <= 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) takeup_expect.push_back(predict_takeup(cmd_ch.data));
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					cmd_ch.valid <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					cmd_ch.data <= cmd_backlog.pop_front();
					cmd_ch.valid <= 1'b1;
					send_gap <= pick_gap();
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: pace ready, compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		btc_res_t want;
		int unsigned g;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left <= 0;
			holdoff_done <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (takeup_expect.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat: consumed=%0d pending=%0d inc=%0d started=%0d",
							res_ch.data.step_consumed, res_ch.data.pending_steps,
							res_ch.data.step_increment, res_ch.data.takeup_started);
				end else begin
					want = takeup_expect.pop_front();
					if (res_ch.data.step_consumed !== want.step_consumed ||
						res_ch.data.pending_steps !== want.pending_steps ||
						res_ch.data.step_increment !== want.step_increment ||
						res_ch.data.takeup_started !== want.takeup_started) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d %s",
								res_ch.data.step_consumed, res_ch.data.pending_steps,
								res_ch.data.step_increment, res_ch.data.takeup_started,
								want.step_consumed, want.pending_steps,
								want.step_increment, want.takeup_started,
								"(consumed/pending/increment/started)");
					end
				end
			end
			if (holdoff_req && !holdoff_done) begin
				// long hold so the block backs up and drops cmd ready
				holdoff_done <= 1'b1;
				stall_left <= HOLDOFF_LEN;
				res_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				res_ch.ready <= 1'b0;
			end else begin
				g = pick_gap();
				res_ch.ready <= (g == 0);
				if (g != 0) stall_left <= g - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("[backlash_takeup_controller] ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_TAKEUP_X: takeup_len[0] = val[STEPS_W-1:0];
		CFG_TAKEUP_Z: takeup_len[1] = val[STEPS_W-1:0];
		CFG_MIN_X:    rate_min[0] = val;
		CFG_MIN_Z:    rate_min[1] = val;
		CFG_MAX_X:    rate_max[0] = val;
		CFG_MAX_Z:    rate_max[1] = val;
		CFG_FM_MODE:  fm_mode = val[1:0];
		CFG_REF_DIRS: ref_dirs = val[1:0];
		default: ;
		endcase
	endtask

	task automatic apply_setup(input logic [STEPS_W-1:0] len_x, input logic [STEPS_W-1:0] len_z,
		input logic [RATE_W-1:0] mn_x, input logic [RATE_W-1:0] mn_z,
		input logic [RATE_W-1:0] mx_x, input logic [RATE_W-1:0] mx_z,
		input logic [1:0] fm, input logic [1:0] rd);
		write_reg(CFG_TAKEUP_X, CFG_DATA_W'(len_x));
		write_reg(CFG_TAKEUP_Z, CFG_DATA_W'(len_z));
		write_reg(CFG_MIN_X, mn_x);
		write_reg(CFG_MIN_Z, mn_z);
		write_reg(CFG_MAX_X, mx_x);
		write_reg(CFG_MAX_Z, mx_z);
		write_reg(CFG_FM_MODE, CFG_DATA_W'(fm));
		write_reg(CFG_REF_DIRS, CFG_DATA_W'(rd));
	endtask

	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || cmd_ch.valid || takeup_expect.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [STEPS_W-1:0] pick_len();
		int unsigned x;
		x = $urandom_range(0, 9);
		if (x == 0) return '0;
		if (x == 1) return '1;
		if (x == 2) return STEPS_W'($urandom);
		return STEPS_W'($urandom_range(1, 6));
	endfunction

	function automatic logic [RATE_W-1:0] pick_rate();
		int unsigned x;
		x = $urandom_range(0, 7);
		if (x == 0) return RATE_W'(1);
		if (x == 1) return '1;
		if (x < 5) return RATE_W'($urandom_range(1, 1048575));
		return RATE_W'($urandom_range(1, 200000));
	endfunction

	initial begin
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;
		for (int b = 0; b < AXES; b++) begin
			takeup_len[b] = '0;
			rate_min[b] = RATE_W'(1);
			rate_max[b] = RATE_W'(1);
			remaining[b] = '0;
			synced[b] = 1'b0;
			prev_dir[b] = 1'b0;
			takeup_dir[b] = 1'b0;
			phase_inc[b] = INC_W'(1);
			gen_dir[b] = 1'b0;
		end
		fm_mode = '0;
		ref_dirs = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// defaults: zero take-up length, rates pinned at 1
		cmd_backlog.push_back(make_cmd(OP_ARM, 1'b0, 1'b1, 1'b1, '1, '0));
		cmd_backlog.push_back(make_cmd(OP_QUEUE, 1'b0, 1'b1, 1'b1, '0, '0));
		cmd_backlog.push_back(make_cmd(OP_QUEUE, 1'b0, 1'b1, 1'b0, '0, '1));
		cmd_backlog.push_back(make_cmd(OP_QUEUE, 1'b0, 1'b0, 1'b1, '0, 16'd3));
		cmd_backlog.push_back(make_cmd(OP_STEP, 1'b0, 1'b1, 1'b0, '0, '0));
		cmd_backlog.push_back(make_cmd(OP_ABORT, 1'b1, 1'b0, 1'b0, '0, '0));
		cmd_backlog.push_back(make_cmd(OP_STEP, 1'b0, 1'b1, 1'b0, '0, '0));
		cmd_backlog.push_back(make_cmd(OP_NOP, 1'b1, 1'b1, 1'b1, '1, '1));
		cmd_backlog.push_back(make_cmd(OP_INIT, 1'b0, 1'b0, 1'b0, '0, '0));
		wait_drained();

		// unused first-move code, Z min above max, reference dirs Z=1
		apply_setup(16'd2, '1, RATE_W'(1), '1, '1, RATE_W'(1), FM_UNUSED, 2'b10);
		cmd_backlog.push_back(make_cmd(OP_INIT, 1'b1, 1'b0, 1'b0, '0, '0));
		cmd_backlog.push_back(make_cmd(OP_ARM, 1'b0, 1'b1, 1'b0, '1, '0));
		cmd_backlog.push_back(make_cmd(OP_ARM, 1'b0, 1'b1, 1'b1, '0, '0));
		cmd_backlog.push_back(make_cmd(OP_ARM, 1'b0, 1'b1, 1'b1, '1, '0));
		cmd_backlog.push_back(make_cmd(OP_ARM, 1'b0, 1'b0, 1'b1, '1, '0));
		cmd_backlog.push_back(make_cmd(OP_ARM, 1'b0, 1'b1, 1'b1, '1, '0));
		cmd_backlog.push_back(make_cmd(OP_STEP, 1'b0, 1'b1, 1'b0, '0, '0));
		cmd_backlog.push_back(make_cmd(OP_STEP, 1'b0, 1'b1, 1'b0, '0, '0));
		cmd_backlog.push_back(make_cmd(OP_ARM, 1'b0, 1'b0, 1'b1, RATE_W'(777), '0));
		cmd_backlog.push_back(make_cmd(OP_ARM, 1'b1, 1'b0, 1'b1, RATE_W'(5), '0));
		cmd_backlog.push_back(make_cmd(OP_SYNC, 1'b1, 1'b0, 1'b0, '0, '0));
		cmd_backlog.push_back(make_cmd(OP_UNSYNC, 1'b1, 1'b0, 1'b0, '0, '0));
		wait_drained();

		write_reg(CFG_FM_MODE, CFG_DATA_W'(FM_SKIP));
		cmd_backlog.push_back(make_cmd(OP_UNSYNC, 1'b0, 1'b0, 1'b0, '0, '0));
		cmd_backlog.push_back(make_cmd(OP_ARM, 1'b0, 1'b0, 1'b1, RATE_W'(100), '0));
		wait_drained();
		write_reg(CFG_FM_MODE, CFG_DATA_W'(FM_ALWAYS));
		cmd_backlog.push_back(make_cmd(OP_ARM, 1'b0, 1'b1, 1'b1, RATE_W'(100), '0));
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			if (p == 0)
				apply_setup('1, '1, '1, '1, '1, '1, FM_ALWAYS, 2'b11);
			else if (p == 1)
				apply_setup(16'd1, 16'd1, RATE_W'(1), RATE_W'(1), RATE_W'(1), RATE_W'(1),
					FM_SKIP, 2'b00);
			else
				apply_setup(pick_len(), pick_len(), pick_rate(), pick_rate(), pick_rate(),
					pick_rate(), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			no_idle = (p % 4 == 3);
			if (p == 2) holdoff_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) cmd_backlog.push_back(next_random_cmd());
			wait_drained();
		end

		if (mismatch_count == 0) begin
			$display("[backlash_takeup_controller] OK");
		end else begin
			$display("[backlash_takeup_controller] ERROR");
		end
		$finish;
	end

endmodule
